/* rtl/core/cci_pkg.sv */
// ----------------------------------------------------------------------------
// cci_pkg
// Shared types and codes for the circle-circle intersection pipeline.
// ----------------------------------------------------------------------------
package cci_pkg;

  localparam int unsigned CoordWidth = 32;
  localparam int unsigned RadWidth   = CoordWidth - 1;

  localparam logic [1:0] StatusOk         = 2'd0;
  localparam logic [1:0] StatusFar        = 2'd1;
  localparam logic [1:0] StatusContained  = 2'd2;
  localparam logic [1:0] StatusCoincident = 2'd3;

  typedef struct packed {
    logic signed [CoordWidth-1:0] first_center_x;
    logic signed [CoordWidth-1:0] first_center_y;
    logic        [RadWidth-1:0]   first_radius;
    logic signed [CoordWidth-1:0] second_center_x;
    logic signed [CoordWidth-1:0] second_center_y;
    logic        [RadWidth-1:0]   second_radius;
  } cci_in_t;

  typedef struct packed {
    logic        [1:0]            status;
    logic signed [CoordWidth-1:0] point_one_x;
    logic signed [CoordWidth-1:0] point_one_y;
    logic signed [CoordWidth-1:0] point_two_x;
    logic signed [CoordWidth-1:0] point_two_y;
  } cci_out_t;

endpackage

/* rtl/core/cci_sqrt_pipe.sv */
// ----------------------------------------------------------------------------
// cci_sqrt_pipe
// Pipelined floor square root, one root bit per stage, with sideband.
// ----------------------------------------------------------------------------
module cci_sqrt_pipe #(
  parameter int unsigned RW = 33,
  parameter int unsigned SW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [2*RW-1:0] rad_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [RW-1:0]   root_o,
  output logic [SW-1:0]   side_o
);

  logic            vld_s  [RW+1];
  logic [2*RW-1:0] rad_s  [RW+1];
  logic [RW+1:0]   rem_s  [RW+1];
  logic [RW-1:0]   root_s [RW+1];
  logic [SW-1:0]   side_s [RW+1];

  logic [RW-1:0]   vld_q, vld_d;
  logic [2*RW-1:0] rad_q  [RW], rad_d  [RW];
  logic [RW+1:0]   rem_q  [RW], rem_d  [RW];
  logic [RW-1:0]   root_q [RW], root_d [RW];
  logic [SW-1:0]   side_q [RW], side_d [RW];

  always_comb begin
    logic [RW+1:0] sh;
    logic [RW+1:0] trial;
    logic          ge;
    vld_s[0]  = valid_i;
    rad_s[0]  = rad_i;
    rem_s[0]  = '0;
    root_s[0] = '0;
    side_s[0] = side_i;
    for (int k = 0; k < RW; k++) begin
      vld_s[k+1]  = vld_q[k];
      rad_s[k+1]  = rad_q[k];
      rem_s[k+1]  = rem_q[k];
      root_s[k+1] = root_q[k];
      side_s[k+1] = side_q[k];
    end
    for (int k = 0; k < RW; k++) begin
      // bring down the next two radicand bits, try root*4+1
      sh        = {rem_s[k][RW-1:0], rad_s[k][2*RW-1 -: 2]};
      trial     = {root_s[k], 2'b01};
      ge        = (sh >= trial);
      vld_d[k]  = vld_s[k];
      rem_d[k]  = ge ? (sh - trial) : sh;
      root_d[k] = {root_s[k][RW-2:0], ge};
      rad_d[k]  = rad_s[k] << 2;
      side_d[k] = side_s[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
      side_q <= side_d;
    end
  end

  assign valid_o = vld_s[RW];
  assign root_o  = root_s[RW];
  assign side_o  = side_s[RW];

endmodule

/* rtl/core/cci_div_pipe.sv */
// ----------------------------------------------------------------------------
// cci_div_pipe
// Pipelined restoring divider, one quotient bit per stage, shared divisor
// across lanes. Quotient must fit QW bits.
// ----------------------------------------------------------------------------
module cci_div_pipe #(
  parameter int unsigned NW    = 66,
  parameter int unsigned DW    = 33,
  parameter int unsigned QW    = 34,
  parameter int unsigned LANES = 1,
  parameter int unsigned SW    = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [LANES-1:0][NW-1:0]   num_i,
  input  logic [DW-1:0]              den_i,
  input  logic [SW-1:0]              side_i,
  output logic                       valid_o,
  output logic [LANES-1:0][QW-1:0]   quo_o,
  output logic [SW-1:0]              side_o
);

  logic                        vld_s  [QW+1];
  logic [LANES-1:0][DW-1:0]    rem_s  [QW+1];
  logic [LANES-1:0][QW-1:0]    lq_s   [QW+1];
  logic [DW-1:0]               den_s  [QW+1];
  logic [SW-1:0]               side_s [QW+1];

  logic [QW-1:0]               vld_q, vld_d;
  logic [LANES-1:0][DW-1:0]    rem_q  [QW], rem_d  [QW];
  logic [LANES-1:0][QW-1:0]    lq_q   [QW], lq_d   [QW];
  logic [DW-1:0]               den_q  [QW], den_d  [QW];
  logic [SW-1:0]               side_q [QW], side_d [QW];

  always_comb begin
    logic [NW+DW-1:0] ext;
    logic [DW:0]      sh;
    logic [DW:0]      dif;
    logic             ge;
    vld_s[0]  = valid_i;
    den_s[0]  = den_i;
    side_s[0] = side_i;
    for (int l = 0; l < LANES; l++) begin
      // upper numerator bits seed the remainder, the low ones shift in
      ext          = {{DW{1'b0}}, num_i[l]} >> QW;
      rem_s[0][l]  = ext[DW-1:0];
      lq_s[0][l]   = num_i[l][QW-1:0];
    end
    for (int k = 0; k < QW; k++) begin
      vld_s[k+1]  = vld_q[k];
      rem_s[k+1]  = rem_q[k];
      lq_s[k+1]   = lq_q[k];
      den_s[k+1]  = den_q[k];
      side_s[k+1] = side_q[k];
    end
    for (int k = 0; k < QW; k++) begin
      vld_d[k]  = vld_s[k];
      den_d[k]  = den_s[k];
      side_d[k] = side_s[k];
      for (int l = 0; l < LANES; l++) begin
        sh           = {rem_s[k][l], lq_s[k][l][QW-1]};
        dif          = sh - {1'b0, den_s[k]};
        ge           = (sh >= {1'b0, den_s[k]});
        rem_d[k][l]  = ge ? dif[DW-1:0] : sh[DW-1:0];
        lq_d[k][l]   = {lq_s[k][l][QW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      lq_q   <= lq_d;
      den_q  <= den_d;
      side_q <= side_d;
    end
  end

  assign valid_o = vld_s[QW];
  assign quo_o   = lq_s[QW];
  assign side_o  = side_s[QW];

endmodule

/* rtl/core/circle_circle_intersection_top.sv */
// ----------------------------------------------------------------------------
// circle_circle_intersection_top
// Two circles in, their intersection points and a status code out.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake                 payload
//   in        in    in_valid_i / in_stall_o   in_item_i  (cci_in_t)
//   out       out   out_valid_o / out_stall_i out_item_o (cci_out_t)
//
// One item per cycle enters while in_stall_o is low. The pipeline depth is set by
// the two square-root pipes (W+1 and W-1 stages) and the two divider pipes
// (W+1 and W+2 stages), each resolving one bit per stage.
// Reset clears only the valid bits; no clearing pass.
// A stalled output freezes the whole pipeline by one enable; nothing is
// dropped or repeated, and input stall is simply the inverse of that enable.
//
// Flow: offsets -> squares -> D2 -> d=isqrt(D2) -> status, p -> s, 2d
//   -> a = s/2d -> a*a -> r0^2-a^2 -> h=isqrt -> four products -> /d
//   -> signs -> centers -> sums, saturation.
// ----------------------------------------------------------------------------
module circle_circle_intersection_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  cci_pkg::cci_in_t in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output cci_pkg::cci_out_t out_item_o
);

  import cci_pkg::*;

  localparam int unsigned W = CoordWidth;

  localparam logic signed [W+4:0] SatMax = {{6{1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [W+4:0] SatMin = {{6{1'b1}}, {(W-1){1'b0}}};

  // --- stage payloads -------------------------------------------------------
  typedef struct packed {
    logic signed [W-1:0] x0;
    logic signed [W-1:0] y0;
    logic [W-2:0]        r0;
    logic [W-2:0]        r1;
    logic                dxs;
    logic                dys;
    logic [W:0]          dxm;
    logic [W:0]          dym;
  } s1_t;

  typedef struct packed {
    s1_t            b;
    logic [2*W+1:0] dxsq;
    logic [2*W+1:0] dysq;
    logic [2*W-3:0] r0sq;
    logic [2*W-3:0] r1sq;
  } s2_t;

  typedef struct packed {
    s1_t            b;
    logic [2*W-3:0] r0sq;
    logic [2*W-3:0] r1sq;
    logic [2*W+1:0] d2;
  } s3_t;

  typedef struct packed {
    logic signed [W-1:0] x0;
    logic signed [W-1:0] y0;
    logic                dxs;
    logic                dys;
    logic [W:0]          dxm;
    logic [W:0]          dym;
    logic [2*W-3:0]      r0sq;
    logic [W:0]          d;
    logic [1:0]          status;
  } com_t;

  typedef struct packed {
    com_t           c;
    logic [2*W-3:0] r1sq;
    logic [2*W+1:0] p;
  } s4_t;

  typedef struct packed {
    com_t c;
    logic neg;
  } ds_t;

  typedef struct packed {
    ds_t            b;
    logic [2*W+1:0] s;
    logic [W+1:0]   den2;
  } s5_t;

  typedef struct packed {
    ds_t            b;
    logic [W:0]     amag;
    logic [2*W+1:0] a2;
  } s6_t;

  typedef struct packed {
    ds_t        b;
    logic [W:0] amag;
  } ss_t;

  typedef struct packed {
    ss_t            b;
    logic [2*W-3:0] hrad;
  } s7_t;

  typedef struct packed {
    logic signed [W-1:0] x0;
    logic signed [W-1:0] y0;
    logic [1:0]          status;
    logic [3:0]          sgn;
  } mt_t;

  typedef struct packed {
    mt_t                       m;
    logic [3:0][2*W+1:0]       pr;
    logic [W:0]                d;
  } s8_t;

  typedef struct packed {
    logic signed [W-1:0] x0;
    logic signed [W-1:0] y0;
    logic [1:0]          status;
    logic signed [W+2:0] qx;
    logic signed [W+2:0] qy;
    logic signed [W+2:0] rx;
    logic signed [W+2:0] ry;
  } s9_t;

  typedef struct packed {
    logic [1:0]          status;
    logic signed [W+3:0] x2;
    logic signed [W+3:0] y2;
    logic signed [W+2:0] rx;
    logic signed [W+2:0] ry;
  } s10_t;

  function automatic logic [W-1:0] sat(input logic signed [W+4:0] v);
    logic [W-1:0] r;
    if (v > SatMax) begin
      r = SatMax[W-1:0];
    end else if (v < SatMin) begin
      r = SatMin[W-1:0];
    end else begin
      r = v[W-1:0];
    end
    return r;
  endfunction

  logic pipe_en;

  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q;
  logic s6_vld_q, s7_vld_q, s8_vld_q, s9_vld_q, s10_vld_q, out_vld_q;
  s1_t  s1_q, s1_d;
  s2_t  s2_q, s2_d;
  s3_t  s3_q, s3_d;
  s4_t  s4_q, s4_d;
  s5_t  s5_q, s5_d;
  s6_t  s6_q, s6_d;
  s7_t  s7_q, s7_d;
  s8_t  s8_q, s8_d;
  s9_t  s9_q, s9_d;
  s10_t s10_q, s10_d;
  cci_out_t out_q, out_d;

  logic                sq1_vld, sq2_vld, dva_vld, dv4_vld;
  logic [W:0]          sq1_root;
  logic [$bits(s3_t)-1:0] sq1_side;
  logic [0:0][W:0]     dva_quo;
  logic [$bits(ds_t)-1:0] dva_side;
  logic [W-2:0]        sq2_root;
  logic [$bits(ss_t)-1:0] sq2_side;
  logic [3:0][W+1:0]   dv4_quo;
  logic [$bits(mt_t)-1:0] dv4_side;

  // global advance: hold everything while a result waits
  assign pipe_en    = !out_vld_q || !out_stall_i;
  assign in_stall_o = !pipe_en;

  // --- stage 1: center offsets and magnitudes --------------------------------
  logic signed [W:0] dx_w, dy_w;
  assign dx_w = $signed({in_item_i.second_center_x[W-1], in_item_i.second_center_x})
              - $signed({in_item_i.first_center_x[W-1], in_item_i.first_center_x});
  assign dy_w = $signed({in_item_i.second_center_y[W-1], in_item_i.second_center_y})
              - $signed({in_item_i.first_center_y[W-1], in_item_i.first_center_y});

  always_comb begin
    s1_d.x0  = in_item_i.first_center_x;
    s1_d.y0  = in_item_i.first_center_y;
    s1_d.r0  = in_item_i.first_radius;
    s1_d.r1  = in_item_i.second_radius;
    s1_d.dxs = dx_w[W];
    s1_d.dys = dy_w[W];
    s1_d.dxm = dx_w[W] ? (~unsigned'(dx_w) + 1'b1) : unsigned'(dx_w);
    s1_d.dym = dy_w[W] ? (~unsigned'(dy_w) + 1'b1) : unsigned'(dy_w);
  end

  // --- stage 2: squares -----------------------------------------------------
  always_comb begin
    s2_d.b    = s1_q;
    s2_d.dxsq = s1_q.dxm * s1_q.dxm;
    s2_d.dysq = s1_q.dym * s1_q.dym;
    s2_d.r0sq = s1_q.r0 * s1_q.r0;
    s2_d.r1sq = s1_q.r1 * s1_q.r1;
  end

  // --- stage 3: squared center distance ------------------------------------
  always_comb begin
    s3_d.b    = s2_q.b;
    s3_d.r0sq = s2_q.r0sq;
    s3_d.r1sq = s2_q.r1sq;
    s3_d.d2   = s2_q.dxsq + s2_q.dysq;
  end

  cci_sqrt_pipe #(
    .RW(W + 1),
    .SW($bits(s3_t))
  ) u_sqrt_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .valid_i(s3_vld_q),
    .rad_i  (s3_q.d2),
    .side_i (s3_q),
    .valid_o(sq1_vld),
    .root_o (sq1_root),
    .side_o (sq1_side)
  );

  // --- stage 4: classification and r0^2 + D2 --------------------------------
  s3_t        sq1_s;
  logic [W-1:0] rsum;
  logic [W-2:0] rdiff;
  assign sq1_s = s3_t'(sq1_side);
  assign rsum  = {1'b0, sq1_s.b.r0} + {1'b0, sq1_s.b.r1};
  assign rdiff = (sq1_s.b.r0 > sq1_s.b.r1) ? (sq1_s.b.r0 - sq1_s.b.r1)
                                           : (sq1_s.b.r1 - sq1_s.b.r0);

  always_comb begin
    s4_d.c.x0   = sq1_s.b.x0;
    s4_d.c.y0   = sq1_s.b.y0;
    s4_d.c.dxs  = sq1_s.b.dxs;
    s4_d.c.dys  = sq1_s.b.dys;
    s4_d.c.dxm  = sq1_s.b.dxm;
    s4_d.c.dym  = sq1_s.b.dym;
    s4_d.c.r0sq = sq1_s.r0sq;
    s4_d.c.d    = sq1_root;
    if (sq1_root > {1'b0, rsum}) begin
      s4_d.c.status = StatusFar;
    end else if (sq1_root < {2'b00, rdiff}) begin
      s4_d.c.status = StatusContained;
    end else if (sq1_root == '0) begin
      s4_d.c.status = StatusCoincident;
    end else begin
      s4_d.c.status = StatusOk;
    end
    s4_d.r1sq = sq1_s.r1sq;
    s4_d.p    = {4'b0000, sq1_s.r0sq} + sq1_s.d2;
  end

  // --- stage 5: |p - r1^2| with its sign, divisor 2d --------------------------
  logic [2*W+1:0] r1sq_w;
  assign r1sq_w = {4'b0000, s4_q.r1sq};

  always_comb begin
    s5_d.b.c   = s4_q.c;
    s5_d.b.neg = (s4_q.p < r1sq_w);
    s5_d.s     = (s4_q.p < r1sq_w) ? (r1sq_w - s4_q.p) : (s4_q.p - r1sq_w);
    s5_d.den2  = {s4_q.c.d, 1'b0};
  end

  cci_div_pipe #(
    .NW   (2 * W + 2),
    .DW   (W + 2),
    .QW   (W + 1),
    .LANES(1),
    .SW   ($bits(ds_t))
  ) u_div_along (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .valid_i(s5_vld_q),
    .num_i  (s5_q.s),
    .den_i  (s5_q.den2),
    .side_i (s5_q.b),
    .valid_o(dva_vld),
    .quo_o  (dva_quo),
    .side_o (dva_side)
  );

  // --- stage 6: a^2 ---------------------------------------------------------
  always_comb begin
    s6_d.b    = ds_t'(dva_side);
    s6_d.amag = dva_quo[0];
    s6_d.a2   = dva_quo[0] * dva_quo[0];
  end

  // --- stage 7: chord radicand, zero when a^2 overshoots ----------------------
  always_comb begin
    s7_d.b.b    = s6_q.b;
    s7_d.b.amag = s6_q.amag;
    if ({4'b0000, s6_q.b.c.r0sq} >= s6_q.a2) begin
      s7_d.hrad = s6_q.b.c.r0sq - s6_q.a2[2*W-3:0];
    end else begin
      s7_d.hrad = '0;
    end
  end

  cci_sqrt_pipe #(
    .RW(W - 1),
    .SW($bits(ss_t))
  ) u_sqrt_chord (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .valid_i(s7_vld_q),
    .rad_i  (s7_q.hrad),
    .side_i (s7_q.b),
    .valid_o(sq2_vld),
    .root_o (sq2_root),
    .side_o (sq2_side)
  );

  // --- stage 8: four magnitude products -------------------------------------
  // lanes: dx*a, dy*a, -dy*h, dx*h
  ss_t      sq2_s;
  logic [W:0] h_w;
  assign sq2_s = ss_t'(sq2_side);
  assign h_w   = {2'b00, sq2_root};

  always_comb begin
    s8_d.m.x0     = sq2_s.b.c.x0;
    s8_d.m.y0     = sq2_s.b.c.y0;
    s8_d.m.status = sq2_s.b.c.status;
    s8_d.m.sgn[0] = sq2_s.b.c.dxs ^ sq2_s.b.neg;
    s8_d.m.sgn[1] = sq2_s.b.c.dys ^ sq2_s.b.neg;
    s8_d.m.sgn[2] = !sq2_s.b.c.dys;
    s8_d.m.sgn[3] = sq2_s.b.c.dxs;
    s8_d.pr[0]    = sq2_s.b.c.dxm * sq2_s.amag;
    s8_d.pr[1]    = sq2_s.b.c.dym * sq2_s.amag;
    s8_d.pr[2]    = sq2_s.b.c.dym * h_w;
    s8_d.pr[3]    = sq2_s.b.c.dxm * h_w;
    s8_d.d        = sq2_s.b.c.d;
  end

  cci_div_pipe #(
    .NW   (2 * W + 2),
    .DW   (W + 1),
    .QW   (W + 2),
    .LANES(4),
    .SW   ($bits(mt_t))
  ) u_div_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .valid_i(s8_vld_q),
    .num_i  (s8_q.pr),
    .den_i  (s8_q.d),
    .side_i (s8_q.m),
    .valid_o(dv4_vld),
    .quo_o  (dv4_quo),
    .side_o (dv4_side)
  );

  // --- stage 9: signs back on (truncation toward zero) -----------------------
  mt_t dv4_s;
  logic [3:0][W+2:0] qsg;
  assign dv4_s = mt_t'(dv4_side);

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      qsg[l] = dv4_s.sgn[l] ? (~{1'b0, dv4_quo[l]} + 1'b1) : {1'b0, dv4_quo[l]};
    end
    s9_d.x0     = dv4_s.x0;
    s9_d.y0     = dv4_s.y0;
    s9_d.status = dv4_s.status;
    s9_d.qx     = $signed(qsg[0]);
    s9_d.qy     = $signed(qsg[1]);
    s9_d.rx     = $signed(qsg[2]);
    s9_d.ry     = $signed(qsg[3]);
  end

  // --- stage 10: chord midpoint ---------------------------------------------
  always_comb begin
    s10_d.status = s9_q.status;
    s10_d.x2     = $signed(s9_q.x0) + $signed(s9_q.qx);
    s10_d.y2     = $signed(s9_q.y0) + $signed(s9_q.qy);
    s10_d.rx     = s9_q.rx;
    s10_d.ry     = s9_q.ry;
  end

  // --- stage 11: the two points, saturated, zero unless ok, into the output register ---
  logic signed [W+4:0] p1x, p1y, p2x, p2y;
  assign p1x = $signed(s10_q.x2) + $signed(s10_q.rx);
  assign p1y = $signed(s10_q.y2) + $signed(s10_q.ry);
  assign p2x = $signed(s10_q.x2) - $signed(s10_q.rx);
  assign p2y = $signed(s10_q.y2) - $signed(s10_q.ry);

  always_comb begin
    out_d.status = s10_q.status;
    if (s10_q.status == StatusOk) begin
      out_d.point_one_x = sat(p1x);
      out_d.point_one_y = sat(p1y);
      out_d.point_two_x = sat(p2x);
      out_d.point_two_y = sat(p2y);
    end else begin
      out_d.point_one_x = '0;
      out_d.point_one_y = '0;
      out_d.point_two_x = '0;
      out_d.point_two_y = '0;
    end
  end

  // --- registers ------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      s6_vld_q  <= 1'b0;
      s7_vld_q  <= 1'b0;
      s8_vld_q  <= 1'b0;
      s9_vld_q  <= 1'b0;
      s10_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (pipe_en) begin
      s1_vld_q  <= in_valid_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= sq1_vld;
      s5_vld_q  <= s4_vld_q;
      s6_vld_q  <= dva_vld;
      s7_vld_q  <= s6_vld_q;
      s8_vld_q  <= sq2_vld;
      s9_vld_q  <= dv4_vld;
      s10_vld_q <= s9_vld_q;
      out_vld_q <= s10_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s1_q  <= s1_d;
      s2_q  <= s2_d;
      s3_q  <= s3_d;
      s4_q  <= s4_d;
      s5_q  <= s5_d;
      s6_q  <= s6_d;
      s7_q  <= s7_d;
      s8_q  <= s8_d;
      s9_q  <= s9_d;
      s10_q <= s10_d;
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for circle_circle_intersection_top. Circle pairs go in
// through the valid/stall handshake and every result is checked against a
// bit-accurate model of the intersection math. Both sides idle at random, and
// the output is held off long enough once to back the pipeline up.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cci_pkg::*;

  // Expected intersections, kept in acceptance order
  class intersect_board;
    cci_out_t pending_q[$];
    int       errors;

    function automatic logic [63:0] root_floor(logic [127:0] n);
      logic [63:0] r, t;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (!(n < 128'(t) * 128'(t))) r = t;
      end
      return r;
    endfunction

    function automatic logic [63:0] clamp60(logic [127:0] v);
      logic [127:0] lim;
      lim = 128'd1 << 60;
      return (v > lim) ? lim[63:0] : v[63:0];
    endfunction

    function automatic logic [63:0] abs64(longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // u*v/d toward zero, magnitude clamped to 2^60
    function automatic longint scale_div(longint u, longint v, logic [63:0] d);
      logic [63:0] m;
      m = clamp60((128'(abs64(u)) * 128'(abs64(v))) / 128'(d));
      return ((u < 0) != (v < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [31:0] sat32(longint v);
      if (v > 64'sd2147483647) return 32'h7fff_ffff;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
    endfunction

    function automatic cci_out_t solve_pair(cci_in_t c);
      longint      x0, y0, dx, dy, a, x2, y2, rx, ry;
      logic [127:0] d2, r0sq, r1sq, p, s, a2;
      logic [63:0] d, r0, r1, gap, amag, h;
      bit          neg;
      cci_out_t    o;
      x0 = longint'(c.first_center_x);
      y0 = longint'(c.first_center_y);
      dx = longint'(c.second_center_x) - x0;
      dy = longint'(c.second_center_y) - y0;
      r0 = 64'(c.first_radius);
      r1 = 64'(c.second_radius);
      d2 = 128'(abs64(dx)) * 128'(abs64(dx)) + 128'(abs64(dy)) * 128'(abs64(dy));
      d = root_floor(d2);
      gap = (r0 > r1) ? r0 - r1 : r1 - r0;
      o = '0;
      if (d > r0 + r1) o.status = StatusFar;
      else if (d < gap) o.status = StatusContained;
      else if (d == 0) o.status = StatusCoincident;
      else begin
        r0sq = 128'(r0) * 128'(r0);
        r1sq = 128'(r1) * 128'(r1);
        p = r0sq + d2;
        neg = p < r1sq;
        s = neg ? r1sq - p : p - r1sq;
        amag = clamp60(s / 128'(d << 1));
        a = neg ? -longint'(amag) : longint'(amag);
        a2 = 128'(amag) * 128'(amag);
        h = (r0sq < a2) ? 64'd0 : root_floor(r0sq - a2);
        x2 = x0 + scale_div(dx, a, d);
        y2 = y0 + scale_div(dy, a, d);
        rx = scale_div(-dy, longint'(h), d);
        ry = scale_div(dx, longint'(h), d);
        o.status      = StatusOk;
        o.point_one_x = sat32(x2 + rx);
        o.point_one_y = sat32(y2 + ry);
        o.point_two_x = sat32(x2 - rx);
        o.point_two_y = sat32(y2 - ry);
      end
      return o;
    endfunction

    function void note_input(cci_in_t c);
      pending_q.push_back(solve_pair(c));
    endfunction

    function void check_result(cci_out_t got);
      cci_out_t want;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp st=%0d p1=(%h,%h) p2=(%h,%h) got st=%0d p1=(%h,%h) p2=(%h,%h)",
                   want.status, want.point_one_x, want.point_one_y, want.point_two_x,
                   want.point_two_y, got.status, got.point_one_x, got.point_one_y,
                   got.point_two_x, got.point_two_y);
      end
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  cci_in_t  in_item_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  cci_out_t out_item_o;

  intersect_board board = new();
  bit idle_on;      // random gaps on both sides
  bit hold_go;      // request one long output hold-off

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  circle_circle_intersection_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_item_o(out_item_o)
  );

  // Receiver: random stalls, plus one long hold-off counted here so the
  // pipeline fills and pushes back on the input
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_go) begin
        hold_go = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else begin
        out_stall_i = idle_on && ($urandom_range(99) < 27);
      end
    end
  end

  // Results are taken at the rising edge they are accepted on
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(out_item_o);
  end

  // Offer one item, holding it steady until the block takes it
  task automatic send_circles(cci_in_t c);
    while (idle_on && ($urandom_range(99) < 27)) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_item_i = c;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    board.note_input(c);
    @(negedge clk_i);
  endtask

  function automatic cci_in_t make_pair(logic [31:0] x0, logic [31:0] y0, logic [30:0] r0,
                                        logic [31:0] x1, logic [31:0] y1, logic [30:0] r1);
    cci_in_t c;
    c.first_center_x = x0;  c.first_center_y = y0;  c.first_radius = r0;
    c.second_center_x = x1; c.second_center_y = y1; c.second_radius = r1;
    return c;
  endfunction

  // Mostly well-formed pairs at a random scale; some raw noise
  function automatic cci_in_t random_pair();
    int          kind, k;
    logic [31:0] x0, y0, span, dx, dy;
    logic [30:0] r0, r1;
    kind = $urandom_range(9);
    if (kind == 0)
      return make_pair($urandom, $urandom, 31'($urandom), $urandom, $urandom, 31'($urandom));
    k = $urandom_range(2, 30);
    x0 = $signed($urandom) >>> $urandom_range(1, 31);
    y0 = $signed($urandom) >>> $urandom_range(1, 31);
    r0 = 31'(($urandom & ((32'd1 << k) - 1)) | 32'd1);
    r1 = 31'(($urandom & ((32'd1 << k) - 1)) | 32'd1);
    span = (32'(r0) + 32'(r1)) >> 1;
    dx = $urandom_range(span) ; dy = $urandom_range(span);
    if ($urandom_range(1)) dx = -dx;
    if ($urandom_range(1)) dy = -dy;
    case (kind)
      8: return make_pair(x0, y0, r0, x0 + 32'(r0) + 32'(r1), y0, r1);   // outer tangent
      9: return make_pair(x0, y0, r0, x0, y0, r0);                       // same circle
      7: return make_pair(x0, y0, r0, x0 + dx * 3, y0 + dy * 3, r1);     // often too far
      default: return make_pair(x0, y0, r0, x0 + dx, y0 + dy, r1);
    endcase
  endfunction

  initial begin
    logic [31:0] mx, mn;
    logic [30:0] rmax;
    mx = 32'h7fff_ffff; mn = 32'h8000_0000; rmax = '1;
    idle_on = 1'b0;
    hold_go = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: extremes, each status, tangency, saturation
    send_circles(make_pair(0, 0, 0, 0, 0, 0));                          // zero circles
    send_circles(make_pair(0, 0, 31'd65536, 0, 0, 31'd65536));          // coincident
    send_circles(make_pair(0, 0, 31'd65536, 0, 0, 31'd131072));         // same center, contained
    send_circles(make_pair(0, 0, 31'd655360, 32'd65536, 0, 31'd65536)); // contained
    send_circles(make_pair(0, 0, 31'd65536, 32'd1310720, 0, 31'd65536));// too far
    send_circles(make_pair(0, 0, 31'd65536, 32'd131072, 0, 31'd65536)); // outer tangent
    send_circles(make_pair(0, 0, 31'd131072, 32'd65536, 0, 31'd65536)); // inner tangent
    send_circles(make_pair(0, 0, 31'd65536, 32'd65536, 0, 31'd65536));  // two points
    send_circles(make_pair(-32'sd196608, -32'sd65536, 31'd200000,
                           -32'sd65536, 32'sd65536, 31'd150000));
    send_circles(make_pair(mn, mn, 0, mx, mx, 0));                      // far corners
    send_circles(make_pair(mn, mn, rmax, mx, mx, rmax));
    send_circles(make_pair(mx, mx, rmax, mx, mx - 32'd1, rmax));        // near edge, saturates
    send_circles(make_pair(mn, mn, rmax, mn + 32'd5, mn, rmax));
    send_circles(make_pair(mn, 0, rmax, mx, 0, rmax));                  // d just above 2*rmax
    send_circles(make_pair(0, mn, rmax, 0, mx, 31'd1));
    send_circles(make_pair(mx, mn, rmax, mx, mn, 0));                   // contained, zero r1
    send_circles(make_pair(0, 0, 31'd3, 32'd1, 32'd1, 31'd2));          // tiny codes
    send_circles(make_pair(32'd1000, 32'd1000, rmax, 32'd1000 + 32'h7fff_0000, 32'd1000,
                           31'h4000_0000));
    send_circles(make_pair(32'd5, -32'sd7, 31'd9, 32'd5, -32'sd7, 31'd10));

    // Random, first stretch with no idling at all
    repeat (100) send_circles(random_pair());
    idle_on = 1'b1;
    repeat (100) send_circles(random_pair());
    hold_go = 1'b1;   // output held off while input keeps coming
    repeat (300) send_circles(random_pair());
    in_valid_i = 1'b0;

    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
